[rtl/core/mh_pkg.sv]
// Types, constants and the arctangent table shared by the heading pipeline.
package mh_pkg;

   localparam int RAW_W     = 16;
   localparam int FIELD_W   = 18;
   localparam int HEAD_W    = 16;
   localparam int ANG_W     = 32;
   localparam int PRE_SHIFT = 24;
   localparam int VEC_W     = 45;
   localparam int PROD_W    = ANG_W + HEAD_W;
   localparam int TABLE_LEN = 24;
   localparam int TAB_IDX_W = $clog2(TABLE_LEN);

   localparam logic [HEAD_W-1:0] FULL_TURN  = 16'd46080;
   localparam logic [ANG_W-1:0]  HALF_TURN  = 32'h8000_0000;
   localparam logic [PROD_W-1:0] ROUND_HALF = 48'h0000_8000_0000;

   typedef logic [ANG_W-1:0] atan_table_type [TABLE_LEN];

   // atan(2^-i) in units of 2^-32 turn
   localparam atan_table_type ATAN_TABLE = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
      32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
   };

   typedef struct packed {
      logic                      conv;
      logic                      zero;
      logic signed [FIELD_W-1:0] fx;
      logic signed [FIELD_W-1:0] fy;
      logic signed [FIELD_W-1:0] fz;
      logic signed [VEC_W-1:0]   x;
      logic signed [VEC_W-1:0]   y;
      logic [ANG_W-1:0]          ang;
   } cordic_type;

   typedef struct packed {
      logic                      conv;
      logic                      zero;
      logic signed [FIELD_W-1:0] fx;
      logic signed [FIELD_W-1:0] fy;
      logic signed [FIELD_W-1:0] fz;
      logic [PROD_W-1:0]         prod;
   } scale_type;

endpackage

[rtl/core/mh_if.sv]
// Valid/ready channel interfaces for samples in and converted results out.
interface mh_req_if;
   logic                              valid;
   logic                              ready;
   logic                              read_ok;
   logic signed [mh_pkg::RAW_W-1:0]   raw_x;
   logic signed [mh_pkg::RAW_W-1:0]   raw_y;
   logic signed [mh_pkg::RAW_W-1:0]   raw_z;

   modport source (output valid, read_ok, raw_x, raw_y, raw_z, input ready);
   modport sink   (input valid, read_ok, raw_x, raw_y, raw_z, output ready);
endinterface

interface mh_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              valid_res;
   logic signed [mh_pkg::FIELD_W-1:0] field_x;
   logic signed [mh_pkg::FIELD_W-1:0] field_y;
   logic signed [mh_pkg::FIELD_W-1:0] field_z;
   logic [mh_pkg::HEAD_W-1:0]         heading_deg;

   modport source (output valid, valid_res, field_x, field_y, field_z, heading_deg,
                   input ready);
   modport sink   (input valid, valid_res, field_x, field_y, field_z, heading_deg,
                   output ready);
endinterface

[rtl/core/mh_front.sv]
// Input stage: scales the axes, gates invalid samples and folds the vector into x >= 0.
module mh_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            sensor_ready,
   input  logic                            valid_in,
   output logic                            ready_out,
   input  logic                            read_ok,
   input  logic signed [mh_pkg::RAW_W-1:0] raw_x,
   input  logic signed [mh_pkg::RAW_W-1:0] raw_y,
   input  logic signed [mh_pkg::RAW_W-1:0] raw_z,
   output logic                            valid_out,
   input  logic                            ready_in,
   output mh_pkg::cordic_type              data_out
);

   logic                                valid_ff;
   mh_pkg::cordic_type                  data_ff;
   mh_pkg::cordic_type                  data_in;
   logic                                conv;
   logic signed [mh_pkg::FIELD_W-1:0]   fx;
   logic signed [mh_pkg::FIELD_W-1:0]   fy;
   logic signed [mh_pkg::FIELD_W-1:0]   fz;
   logic signed [mh_pkg::VEC_W-1:0]     xs;
   logic signed [mh_pkg::VEC_W-1:0]     ys;

   assign conv = sensor_ready & read_ok;

   always_comb begin
      fx = (mh_pkg::FIELD_W'(raw_x) <<< 1) + mh_pkg::FIELD_W'(raw_x);
      fy = (mh_pkg::FIELD_W'(raw_y) <<< 1) + mh_pkg::FIELD_W'(raw_y);
      fz = (mh_pkg::FIELD_W'(raw_z) <<< 1) + mh_pkg::FIELD_W'(raw_z);
      if (!conv) begin
         fx = '0;
         fy = '0;
         fz = '0;
      end
      xs = mh_pkg::VEC_W'(fx) <<< mh_pkg::PRE_SHIFT;
      ys = mh_pkg::VEC_W'(fy) <<< mh_pkg::PRE_SHIFT;
      data_in.conv = conv;
      data_in.zero = (fx == '0) && (fy == '0);
      data_in.fx   = fx;
      data_in.fy   = fy;
      data_in.fz   = fz;
      if (xs[mh_pkg::VEC_W-1]) begin
         data_in.x   = -xs;
         data_in.y   = -ys;
         data_in.ang = mh_pkg::HALF_TURN;
      end else begin
         data_in.x   = xs;
         data_in.y   = ys;
         data_in.ang = '0;
      end
   end

   assign ready_out = !valid_ff || ready_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ready_out) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_out) begin
         data_ff <= data_in;
      end
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;

   a_fold_nonneg: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> !data_ff.x[mh_pkg::VEC_W-1])
      else $error("folded x is negative");

endmodule

[rtl/core/mh_rot_stage.sv]
// One CORDIC vectoring micro-rotation with its pipeline register.
module mh_rot_stage #(
   parameter int SHIFT = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               valid_in,
   output logic               ready_out,
   input  mh_pkg::cordic_type data_in,
   output logic               valid_out,
   input  logic               ready_in,
   output mh_pkg::cordic_type data_out
);

   localparam logic [mh_pkg::TAB_IDX_W-1:0] IDX = mh_pkg::TAB_IDX_W'(SHIFT);
   localparam logic [mh_pkg::ANG_W-1:0]     STEP = mh_pkg::ATAN_TABLE[IDX];

   logic                            valid_ff;
   mh_pkg::cordic_type              data_ff;
   mh_pkg::cordic_type              rot_in;
   logic signed [mh_pkg::VEC_W-1:0] xs;
   logic signed [mh_pkg::VEC_W-1:0] ys;

   always_comb begin
      xs     = data_in.x >>> SHIFT;
      ys     = data_in.y >>> SHIFT;
      rot_in = data_in;
      if (!data_in.y[mh_pkg::VEC_W-1]) begin
         rot_in.x   = data_in.x + ys;
         rot_in.y   = data_in.y - xs;
         rot_in.ang = data_in.ang + STEP;
      end else begin
         rot_in.x   = data_in.x - ys;
         rot_in.y   = data_in.y + xs;
         rot_in.ang = data_in.ang - STEP;
      end
   end

   assign ready_out = !valid_ff || ready_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ready_out) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_out) begin
         data_ff <= rot_in;
      end
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;

endmodule

[rtl/core/mh_scale.sv]
// Binary angle to 1/128-degree units: multiply stage, then round, wrap and output register.
module mh_scale (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             valid_in,
   output logic                             ready_out,
   input  mh_pkg::cordic_type               data_in,
   output logic                             valid_out,
   input  logic                             ready_in,
   output logic                             valid_res,
   output logic signed [mh_pkg::FIELD_W-1:0] field_x,
   output logic signed [mh_pkg::FIELD_W-1:0] field_y,
   output logic signed [mh_pkg::FIELD_W-1:0] field_z,
   output logic [mh_pkg::HEAD_W-1:0]        heading_deg
);

   logic                              mul_valid_ff;
   mh_pkg::scale_type                 mul_ff;
   mh_pkg::scale_type                 mul_in;
   logic                              mul_ready;
   logic                              out_valid_ff;
   logic                              conv_ff;
   logic signed [mh_pkg::FIELD_W-1:0] fx_ff;
   logic signed [mh_pkg::FIELD_W-1:0] fy_ff;
   logic signed [mh_pkg::FIELD_W-1:0] fz_ff;
   logic [mh_pkg::HEAD_W-1:0]         head_ff;
   logic [mh_pkg::HEAD_W-1:0]         head_in;
   logic [mh_pkg::PROD_W-1:0]         rounded;

   always_comb begin
      mul_in.conv = data_in.conv;
      mul_in.zero = data_in.zero;
      mul_in.fx   = data_in.fx;
      mul_in.fy   = data_in.fy;
      mul_in.fz   = data_in.fz;
      mul_in.prod = mh_pkg::PROD_W'(data_in.ang) * mh_pkg::PROD_W'(mh_pkg::FULL_TURN);
   end

   always_comb begin
      rounded = mul_ff.prod + mh_pkg::ROUND_HALF;
      head_in = rounded[mh_pkg::PROD_W-1:mh_pkg::ANG_W];
      if (mul_ff.zero || !mul_ff.conv || head_in >= mh_pkg::FULL_TURN) begin
         head_in = '0;
      end
   end

   assign mul_ready = !out_valid_ff || ready_in;
   assign ready_out = !mul_valid_ff || mul_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (ready_out) begin
            mul_valid_ff <= valid_in;
         end
         if (mul_ready) begin
            out_valid_ff <= mul_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready_out) begin
         mul_ff <= mul_in;
      end
      if (mul_ready) begin
         conv_ff <= mul_ff.conv;
         fx_ff   <= mul_ff.fx;
         fy_ff   <= mul_ff.fy;
         fz_ff   <= mul_ff.fz;
         head_ff <= head_in;
      end
   end

   assign valid_out   = out_valid_ff;
   assign valid_res   = conv_ff;
   assign field_x     = fx_ff;
   assign field_y     = fy_ff;
   assign field_z     = fz_ff;
   assign heading_deg = head_ff;

endmodule

[rtl/core/magnetometer_heading.sv]
// Top level of the magnetometer heading pipeline.
// One sample enters per clock while not stalled; every sample yields exactly one result, in
// order. It has one input stage that scales the axes by 3 and folds the vector into
// the right half plane, one register per CORDIC micro-rotation, one multiply stage that turns
// the 32-bit binary angle into 1/128-degree units, and a round/wrap stage that is also the
// output register. Each stage holds its item while the stage after it is full and stalled, so
// back-pressure on the result side lets the pipeline fill its empty slots before it pushes back
// on the sample side. Results are flagged invalid with all fields zero while csr_wdata last
// written is 0 or the sample's read_ok is 0. csr_* writes apply to samples accepted afterwards.
module magnetometer_heading #(
   parameter int ANGLE_STAGES = 16
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     csr_we,
   input  logic     csr_wdata,
   mh_req_if.sink   req,
   mh_rsp_if.source rsp
);

   logic               sensor_ready_ff;
   logic               valid_chain [ANGLE_STAGES+1];
   logic               ready_chain [ANGLE_STAGES+1];
   mh_pkg::cordic_type data_chain  [ANGLE_STAGES+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         sensor_ready_ff <= 1'b0;
      end else if (csr_we) begin
         sensor_ready_ff <= csr_wdata;
      end
   end

   mh_front u_front (
      .clock        (clock),
      .reset        (reset),
      .sensor_ready (sensor_ready_ff),
      .valid_in     (req.valid),
      .ready_out    (req.ready),
      .read_ok      (req.read_ok),
      .raw_x        (req.raw_x),
      .raw_y        (req.raw_y),
      .raw_z        (req.raw_z),
      .valid_out    (valid_chain[0]),
      .ready_in     (ready_chain[0]),
      .data_out     (data_chain[0])
   );

   for (genvar k = 0; k < ANGLE_STAGES; k++) begin : g_rot
      mh_rot_stage #(
         .SHIFT (k)
      ) u_rot (
         .clock     (clock),
         .reset     (reset),
         .valid_in  (valid_chain[k]),
         .ready_out (ready_chain[k]),
         .data_in   (data_chain[k]),
         .valid_out (valid_chain[k+1]),
         .ready_in  (ready_chain[k+1]),
         .data_out  (data_chain[k+1])
      );
   end

   mh_scale u_scale (
      .clock       (clock),
      .reset       (reset),
      .valid_in    (valid_chain[ANGLE_STAGES]),
      .ready_out   (ready_chain[ANGLE_STAGES]),
      .data_in     (data_chain[ANGLE_STAGES]),
      .valid_out   (rsp.valid),
      .ready_in    (rsp.ready),
      .valid_res   (rsp.valid_res),
      .field_x     (rsp.field_x),
      .field_y     (rsp.field_y),
      .field_z     (rsp.field_z),
      .heading_deg (rsp.heading_deg)
   );

   a_head_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.heading_deg < mh_pkg::FULL_TURN)
      else $error("heading out of range");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.valid_res |-> rsp.field_x == '0 && rsp.field_y == '0 &&
         rsp.field_z == '0 && rsp.heading_deg == '0)
      else $error("invalid result carries nonzero fields");

   a_field_mult3: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.valid_res |-> (rsp.field_x >= -98304) && (rsp.field_x <= 98301) &&
         (rsp.field_y >= -98304) && (rsp.field_y <= 98301))
      else $error("scaled field out of range");

endmodule

[test/tb_magnetometer_heading.sv]
// Self-checking testbench for the magnetometer heading pipeline: axis scaling and CORDIC heading.
module tb_magnetometer_heading;

   localparam int STAGES       = 16;
   localparam int LATENCY      = STAGES + 3;
   localparam int IDLE_LIMIT   = 4000;
   localparam int HOLD_CYCLES  = 150;
   localparam int TURN_UNITS   = 46080;

   typedef struct {
      logic                              valid_res;
      logic signed [mh_pkg::FIELD_W-1:0] field_x;
      logic signed [mh_pkg::FIELD_W-1:0] field_y;
      logic signed [mh_pkg::FIELD_W-1:0] field_z;
      logic [mh_pkg::HEAD_W-1:0]         heading_deg;
   } heading_result_type;

   // atan(2^-i), 2^32 units per turn
   localparam logic [31:0] ATAN_BINANG [24] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
      32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
   };

   logic clock;
   logic reset;
   logic csr_we;
   logic csr_wdata;

   mh_req_if req ();
   mh_rsp_if rsp ();

   magnetometer_heading #(
      .ANGLE_STAGES(STAGES)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req       (req.sink),
      .rsp       (rsp.source)
   );

   heading_result_type pending_results[$];
   logic               sensor_ready_copy;
   int                 error_count;
   int                 idle_cycles;
   int                 burst_left;
   bit                 no_gaps;
   int                 hold_request;

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   function automatic logic [mh_pkg::HEAD_W-1:0] cordic_heading(longint fx, longint fy);
      longint      vx;
      longint      vy;
      longint      sx;
      longint      sy;
      logic [31:0] ang;
      logic [63:0] prod;
      int          i;
      if (fx == 0 && fy == 0) begin
         return '0;
      end
      vx  = fx <<< mh_pkg::PRE_SHIFT;
      vy  = fy <<< mh_pkg::PRE_SHIFT;
      ang = '0;
      if (vx < 0) begin
         vx  = -vx;
         vy  = -vy;
         ang = 32'h8000_0000;
      end
      for (i = 0; i < STAGES && i < 24; i++) begin
         sx = vx >>> i;
         sy = vy >>> i;
         if (vy >= 0) begin
            vx  = vx + sy;
            vy  = vy - sx;
            ang = ang + ATAN_BINANG[i];
         end else begin
            vx  = vx - sy;
            vy  = vy + sx;
            ang = ang - ATAN_BINANG[i];
         end
      end
      prod = (64'(ang) * 64'(TURN_UNITS) + 64'h8000_0000) >> 32;
      if (prod >= 64'(TURN_UNITS)) begin
         prod = '0;
      end
      return prod[mh_pkg::HEAD_W-1:0];
   endfunction

   function automatic heading_result_type convert_sample(
         logic ok, logic signed [mh_pkg::RAW_W-1:0] x,
         logic signed [mh_pkg::RAW_W-1:0] y,
         logic signed [mh_pkg::RAW_W-1:0] z);
      heading_result_type r;
      longint             fx;
      longint             fy;
      longint             fz;
      r = '{valid_res: 1'b0, field_x: '0, field_y: '0, field_z: '0, heading_deg: '0};
      if (sensor_ready_copy && ok) begin
         fx            = longint'(x) * 3;
         fy            = longint'(y) * 3;
         fz            = longint'(z) * 3;
         r.valid_res   = 1'b1;
         r.field_x     = fx[mh_pkg::FIELD_W-1:0];
         r.field_y     = fy[mh_pkg::FIELD_W-1:0];
         r.field_z     = fz[mh_pkg::FIELD_W-1:0];
         r.heading_deg = cordic_heading(fx, fy);
      end
      return r;
   endfunction

   function automatic logic signed [mh_pkg::RAW_W-1:0] random_axis();
      int v;
      case ($urandom_range(0, 9))
         0: v = int'($urandom_range(0, 16)) - 8;
         1: begin
            case ($urandom_range(0, 4))
               0: v = 32767;
               1: v = -32768;
               2: v = -32767;
               3: v = 1;
               default: v = 0;
            endcase
         end
         default: v = int'($urandom());
      endcase
      return v[mh_pkg::RAW_W-1:0];
   endfunction

   task automatic send_sample(logic ok, logic signed [mh_pkg::RAW_W-1:0] x,
                              logic signed [mh_pkg::RAW_W-1:0] y,
                              logic signed [mh_pkg::RAW_W-1:0] z);
      int gap;
      @(negedge clock);
      req.valid   <= 1'b1;
      req.read_ok <= ok;
      req.raw_x   <= x;
      req.raw_y   <= y;
      req.raw_z   <= z;
      @(posedge clock);
      while (!req.ready) begin
         @(posedge clock);
      end
      pending_results.push_back(convert_sample(ok, x, y, z));
      if (burst_left > 0) begin
         burst_left--;
      end
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap        = no_gaps ? 0 : $urandom_range(0, 5);
         if (gap > 0) begin
            @(negedge clock);
            req.valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
   endtask

   task automatic drain_results();
      @(negedge clock);
      req.valid <= 1'b0;
      while (pending_results.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_sensor_ready(logic value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      sensor_ready_copy = value;
   endtask

   task automatic random_samples(int count, int fail_pct);
      int n;
      for (n = 0; n < count; n++) begin
         send_sample($urandom_range(0, 99) >= fail_pct, random_axis(), random_axis(),
                     random_axis());
      end
   endtask

   task automatic test_not_ready_after_reset();
      send_sample(1'b1, 16'sd100, 16'sd200, 16'sd300);
      send_sample(1'b0, -16'sd5, 16'sd7, -16'sd9);
      send_sample(1'b1, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
      random_samples(10, 30);
      drain_results();
      write_sensor_ready(1'b0);
      random_samples(10, 30);
      drain_results();
   endtask

   task automatic test_directed_cases();
      write_sensor_ready(1'b1);
      send_sample(1'b1, 16'sd0, 16'sd0, 16'sd0);                // zero vector
      send_sample(1'b1, 16'sd0, 16'sd0, 16'sh7FFF);
      send_sample(1'b1, 16'sh7FFF, 16'sd0, 16'sd0);
      send_sample(1'b1, 16'sh8000, 16'sh8000, 16'sh8000);
      send_sample(1'b1, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      send_sample(1'b1, 16'sd0, 16'sh7FFF, 16'sd1);
      send_sample(1'b1, 16'sd0, 16'sh8000, -16'sd1);
      send_sample(1'b1, 16'sh8000, 16'sd0, 16'sd0);             // negative x, on axis
      send_sample(1'b1, -16'sd1, 16'sd1, 16'sd0);
      send_sample(1'b1, -16'sd1, -16'sd1, 16'sd0);
      send_sample(1'b1, 16'sh8000, 16'sd1, 16'sd0);
      send_sample(1'b1, 16'sh8000, -16'sd1, 16'sd0);
      send_sample(1'b1, 16'sh7FFF, -16'sd1, 16'sd0);            // rounds up to a full turn
      send_sample(1'b1, 16'sh7FFF, -16'sd2, 16'sd0);
      send_sample(1'b1, 16'sd1, -16'sd1, 16'sd0);
      send_sample(1'b1, 16'sd1, 16'sd0, 16'sd0);
      send_sample(1'b1, -16'sd1, 16'sd0, -16'sd1);
      send_sample(1'b1, 16'sd12345, -16'sd23456, 16'sd7777);
      send_sample(1'b0, 16'sd1234, 16'sd4321, 16'sd999);        // failed read
      send_sample(1'b0, -16'sd1, -16'sd1, -16'sd1);
      send_sample(1'b1, 16'sd1, 16'sd1, 16'sd1);
      drain_results();
   endtask

   task automatic test_random_stream();
      random_samples(380, 10);
      drain_results();
   endtask

   task automatic test_ready_cleared();
      write_sensor_ready(1'b0);
      random_samples(40, 20);
      drain_results();
   endtask

   task automatic test_backpressure();
      int n;
      write_sensor_ready(1'b1);
      no_gaps = 1'b1;
      hold_request++;
      for (n = 0; n < 80; n++) begin
         send_sample(1'b1, random_axis(), random_axis(), random_axis());
      end
      no_gaps = 1'b0;
      drain_results();
   endtask

   task automatic test_final_stream();
      write_sensor_ready(1'b1);
      random_samples(100, 15);
      drain_results();
   endtask

   task automatic check_field(string name, longint want, longint got);
      if (want != got) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   // result receiver: stall pattern of its own, plus long hold-offs on request
   initial begin
      int stall_pct;
      int pattern_left;
      int hold_seen;
      rsp.ready    <= 1'b0;
      stall_pct    = 0;
      pattern_left = 0;
      hold_seen    = 0;
      forever begin
         @(negedge clock);
         if (hold_request != hold_seen) begin
            hold_seen = hold_request;
            rsp.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            if (pattern_left == 0) begin
               pattern_left = $urandom_range(16, 96);
               case ($urandom_range(0, 3))
                  0: stall_pct = 0;
                  1: stall_pct = 15;
                  2: stall_pct = 40;
                  default: stall_pct = 70;
               endcase
            end
            pattern_left--;
            rsp.ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      heading_result_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected item, valid_res %0b heading %0d", $time, rsp.valid_res,
                     rsp.heading_deg);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("valid_res", want.valid_res, rsp.valid_res);
            check_field("field_x", want.field_x, rsp.field_x);
            check_field("field_y", want.field_y, rsp.field_y);
            check_field("field_z", want.field_z, rsp.field_z);
            check_field("heading_deg", want.heading_deg, rsp.heading_deg);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      reset             <= 1'b1;
      csr_we            <= 1'b0;
      csr_wdata         <= 1'b0;
      req.valid         <= 1'b0;
      req.read_ok       <= 1'b0;
      req.raw_x         <= '0;
      req.raw_y         <= '0;
      req.raw_z         <= '0;
      sensor_ready_copy = 1'b0;
      burst_left        = 0;
      no_gaps           = 1'b0;
      hold_request      = 0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      test_not_ready_after_reset();
      test_directed_cases();
      test_random_stream();
      test_ready_cleared();
      test_backpressure();
      test_final_stream();

      repeat (LATENCY + 8) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

[magnetometer_heading.f]
rtl/core/mh_pkg.sv
rtl/core/mh_if.sv
rtl/core/mh_front.sv
rtl/core/mh_rot_stage.sv
rtl/core/mh_scale.sv
rtl/core/magnetometer_heading.sv
test/tb_magnetometer_heading.sv
